>>> rtl/core/assert_macros.svh
// Assertion macros for the lock arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an expression at every clock edge outside reset.
`define RWL_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rwl assertion failed");
// Check that an antecedent is followed by a consequent in the next cycle.
`define RWL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwl assertion failed");
`else
`define RWL_ASSERT(label, expr)
`define RWL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Types and codes shared by the reader/writer lock arbiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rwl_pkg;

  localparam int ID_W   = 4;
  localparam int MODE_W = 3;
  localparam int TMO_W  = 16;
  localparam int EV_W   = 3;
  localparam int RC_W   = 5;
  localparam logic [RC_W-1:0] READER_MAX = 5'd31;

  localparam logic [MODE_W-1:0] MODE_ENTER_RD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENTER_WR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT_RD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXIT_WR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd4;

  localparam logic [EV_W-1:0] EV_GRANT      = 3'd0;
  localparam logic [EV_W-1:0] EV_QUEUED     = 3'd1;
  localparam logic [EV_W-1:0] EV_RELEASED   = 3'd2;
  localparam logic [EV_W-1:0] EV_GRANT_LATE = 3'd3;
  localparam logic [EV_W-1:0] EV_TIMEOUT    = 3'd4;
  localparam logic [EV_W-1:0] EV_MISUSE     = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   thread_id;
    logic [TMO_W-1:0]  timeout_ticks;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] who;
    logic [EV_W-1:0] event_res;
    logic            last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_RD,
    ST_POP_DATA,
    ST_TICK_RD,
    ST_TICK_DATA,
    ST_RM_RD,
    ST_RM_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/reader_writer_lock_arbiter_top.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter_top
// Reader/writer lock manager with reader and writer wait queues and per-thread tick timeouts.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the last result of that request is registered, and falls in the cycle
// that carries it. Results appear one per cycle at most on out_res with
// out_valid high for one cycle, and cannot be held off. An exit that wakes
// waiters pops them one at a time, as each pop is one read of the queue RAM.
// A tick visits every thread in turn, reads the tick RAM for each waiting
// thread, and for each expiry scans that thread's queue and closes it up over
// the removed entry. The queue RAM's single read port keeps pops and scans to
// one entry at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module reader_writer_lock_arbiter_top #(
  parameter int THREADS      = 16,
  parameter int TIMEOUT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire rwl_pkg::req_t in_req,
  output logic               out_valid,
  output rwl_pkg::res_t      out_res
);

  localparam int P_W = $clog2(THREADS);
  localparam int A_W = $clog2(2 * THREADS);
  localparam int C_W = $clog2(THREADS + 1);
  localparam int ID_W = rwl_pkg::ID_W;

  rwl_pkg::state_t state_r, state_nxt;
  rwl_pkg::req_t   req_r, req_nxt;
  logic [rwl_pkg::RC_W-1:0] rc_r, rc_nxt;
  logic            wh_r, wh_nxt;
  logic [P_W-1:0]  head_r [2];
  logic [P_W-1:0]  head_nxt [2];
  logic [P_W-1:0]  tail_r [2];
  logic [P_W-1:0]  tail_nxt [2];
  logic [C_W-1:0]  live_r [2];
  logic [C_W-1:0]  live_nxt [2];
  logic [THREADS-1:0] wait_r, wait_nxt;
  logic [THREADS-1:0] inwq_r, inwq_nxt;
  logic            q_r, q_nxt;
  logic [P_W-1:0]  t_r, t_nxt;
  logic [P_W-1:0]  p_r, p_nxt;
  logic [C_W-1:0]  k_r, k_nxt;
  logic            pend_v_r, pend_v_nxt;
  rwl_pkg::res_t   pend_r, pend_nxt;
  logic            out_valid_nxt;
  rwl_pkg::res_t   out_res_nxt;

  logic                    f_we;
  logic [A_W-1:0]          f_waddr, f_raddr;
  logic [ID_W-1:0]         f_wdata, f_rdata;
  logic                    k_we;
  logic [P_W-1:0]          k_waddr, k_raddr;
  logic [TIMEOUT_BITS-1:0] k_wdata, k_rdata;

  logic                    emit_v;
  logic [ID_W-1:0]         emit_who;
  logic [rwl_pkg::EV_W-1:0] emit_ev;
  logic [P_W-1:0]          id_idx;
  logic                    id_ok;
  logic                    qsel;

  function automatic logic [P_W-1:0] ring_inc(input logic [P_W-1:0] p);
    ring_inc = (32'(p) == THREADS - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [P_W-1:0] ring_dec(input logic [P_W-1:0] p);
    ring_dec = (p == '0) ? P_W'(THREADS - 1) : p - 1'b1;
  endfunction

  function automatic logic [A_W-1:0] faddr(input logic q, input logic [P_W-1:0] p);
    faddr = q ? A_W'(THREADS) + A_W'(p) : A_W'(p);
  endfunction

  rwl_ram #(.WIDTH(ID_W), .DEPTH(2 * THREADS)) u_fifo_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  rwl_ram #(.WIDTH(TIMEOUT_BITS), .DEPTH(THREADS)) u_tick_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  assign busy   = (state_r != rwl_pkg::ST_IDLE);
  assign id_idx = P_W'(req_r.thread_id);
  assign id_ok  = (32'(req_r.thread_id) < THREADS);
  assign qsel   = (req_r.mode == rwl_pkg::MODE_ENTER_WR);

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    rc_nxt     = rc_r;
    wh_nxt     = wh_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    live_nxt   = live_r;
    wait_nxt   = wait_r;
    inwq_nxt   = inwq_r;
    q_nxt      = q_r;
    t_nxt      = t_r;
    p_nxt      = p_r;
    k_nxt      = k_r;
    f_we       = 1'b0;
    f_waddr    = faddr(q_r, p_r);
    f_wdata    = f_rdata;
    f_raddr    = faddr(q_r, p_r);
    k_we       = 1'b0;
    k_waddr    = t_r;
    k_wdata    = k_rdata - 1'b1;
    k_raddr    = t_r;
    emit_v     = 1'b0;
    emit_who   = req_r.thread_id;
    emit_ev    = rwl_pkg::EV_MISUSE;

    case (state_r)
      rwl_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = rwl_pkg::ST_EXEC;
        end
      end

      rwl_pkg::ST_EXEC: begin
        state_nxt = rwl_pkg::ST_FLUSH;
        if (req_r.mode == rwl_pkg::MODE_TICK) begin
          t_nxt     = '0;
          state_nxt = rwl_pkg::ST_TICK_RD;
        end else if (req_r.mode <= rwl_pkg::MODE_EXIT_WR) begin
          emit_v = 1'b1;
          if (!id_ok || wait_r[id_idx]) begin
            emit_ev = rwl_pkg::EV_MISUSE;
          end else if ((req_r.mode == rwl_pkg::MODE_ENTER_RD && !wh_r && live_r[1] == '0)
                       || (req_r.mode == rwl_pkg::MODE_ENTER_WR && !wh_r && rc_r == '0)) begin
            if (qsel) begin
              wh_nxt  = 1'b1;
              emit_ev = rwl_pkg::EV_GRANT;
            end else if (rc_r >= rwl_pkg::READER_MAX) begin
              emit_ev = rwl_pkg::EV_MISUSE;
            end else begin
              rc_nxt  = rc_r + 1'b1;
              emit_ev = rwl_pkg::EV_GRANT;
            end
          end else if (req_r.mode == rwl_pkg::MODE_ENTER_RD
                       || req_r.mode == rwl_pkg::MODE_ENTER_WR) begin
            f_we             = 1'b1;
            f_waddr          = faddr(qsel, tail_r[qsel]);
            f_wdata          = req_r.thread_id;
            tail_nxt[qsel]   = ring_inc(tail_r[qsel]);
            live_nxt[qsel]   = live_r[qsel] + 1'b1;
            wait_nxt[id_idx] = 1'b1;
            inwq_nxt[id_idx] = qsel;
            k_we             = 1'b1;
            k_waddr          = id_idx;
            k_wdata          = TIMEOUT_BITS'(req_r.timeout_ticks);
            emit_ev          = rwl_pkg::EV_QUEUED;
          end else if (req_r.mode == rwl_pkg::MODE_EXIT_RD) begin
            if (rc_r == '0) begin
              emit_ev = rwl_pkg::EV_MISUSE;
            end else begin
              rc_nxt  = rc_r - 1'b1;
              emit_ev = rwl_pkg::EV_RELEASED;
              if (rc_r == 5'd1 && live_r[1] != '0) begin
                wh_nxt    = 1'b1;
                q_nxt     = 1'b1;
                state_nxt = rwl_pkg::ST_POP_RD;
              end
            end
          end else begin
            if (!wh_r) begin
              emit_ev = rwl_pkg::EV_MISUSE;
            end else begin
              wh_nxt  = 1'b0;
              emit_ev = rwl_pkg::EV_RELEASED;
              if (live_r[0] != '0) begin
                q_nxt     = 1'b0;
                state_nxt = rwl_pkg::ST_POP_RD;
              end else if (live_r[1] != '0) begin
                wh_nxt    = 1'b1;
                q_nxt     = 1'b1;
                state_nxt = rwl_pkg::ST_POP_RD;
              end
            end
          end
        end
      end

      rwl_pkg::ST_POP_RD: begin
        f_raddr   = faddr(q_r, head_r[q_r]);
        state_nxt = rwl_pkg::ST_POP_DATA;
      end

      rwl_pkg::ST_POP_DATA: begin
        head_nxt[q_r] = ring_inc(head_r[q_r]);
        live_nxt[q_r] = live_r[q_r] - 1'b1;
        wait_nxt[P_W'(f_rdata)] = 1'b0;
        emit_v    = 1'b1;
        emit_who  = f_rdata;
        emit_ev   = rwl_pkg::EV_GRANT_LATE;
        state_nxt = rwl_pkg::ST_FLUSH;
        if (!q_r) begin
          if (rc_r < rwl_pkg::READER_MAX) begin
            rc_nxt = rc_r + 1'b1;
          end
          if (live_r[0] != C_W'(1)) begin
            state_nxt = rwl_pkg::ST_POP_RD;
          end
        end
      end

      rwl_pkg::ST_TICK_RD: begin
        if (wait_r[t_r]) begin
          state_nxt = rwl_pkg::ST_TICK_DATA;
        end else if (32'(t_r) == THREADS - 1) begin
          state_nxt = rwl_pkg::ST_FLUSH;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end

      rwl_pkg::ST_TICK_DATA: begin
        if (k_rdata == TIMEOUT_BITS'(1)) begin
          k_we        = 1'b1;
          wait_nxt[t_r] = 1'b0;
          emit_v      = 1'b1;
          emit_who    = ID_W'(t_r);
          emit_ev     = rwl_pkg::EV_TIMEOUT;
          q_nxt       = inwq_r[t_r];
          p_nxt       = head_r[inwq_r[t_r]];
          k_nxt       = live_r[inwq_r[t_r]];
          state_nxt   = rwl_pkg::ST_RM_RD;
        end else begin
          k_we = (k_rdata != '0);
          if (32'(t_r) == THREADS - 1) begin
            state_nxt = rwl_pkg::ST_FLUSH;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = rwl_pkg::ST_TICK_RD;
          end
        end
      end

      rwl_pkg::ST_RM_RD: begin
        state_nxt = rwl_pkg::ST_RM_CMP;
      end

      rwl_pkg::ST_RM_CMP: begin
        if (f_rdata == ID_W'(t_r)) begin
          state_nxt = rwl_pkg::ST_SH_RD;
        end else if (k_r <= C_W'(1)) begin
          if (32'(t_r) == THREADS - 1) begin
            state_nxt = rwl_pkg::ST_FLUSH;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = rwl_pkg::ST_TICK_RD;
          end
        end else begin
          p_nxt     = ring_inc(p_r);
          k_nxt     = k_r - 1'b1;
          state_nxt = rwl_pkg::ST_RM_RD;
        end
      end

      rwl_pkg::ST_SH_RD: begin
        if (k_r <= C_W'(1)) begin
          live_nxt[q_r] = live_r[q_r] - 1'b1;
          tail_nxt[q_r] = ring_dec(tail_r[q_r]);
          if (32'(t_r) == THREADS - 1) begin
            state_nxt = rwl_pkg::ST_FLUSH;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = rwl_pkg::ST_TICK_RD;
          end
        end else begin
          f_raddr   = faddr(q_r, ring_inc(p_r));
          state_nxt = rwl_pkg::ST_SH_WR;
        end
      end

      rwl_pkg::ST_SH_WR: begin
        f_we      = 1'b1;
        p_nxt     = ring_inc(p_r);
        k_nxt     = k_r - 1'b1;
        state_nxt = rwl_pkg::ST_SH_RD;
      end

      rwl_pkg::ST_FLUSH: begin
        state_nxt = rwl_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = rwl_pkg::ST_IDLE;
      end
    endcase
  end

  // hold one result back so the last one of a request can be marked
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = pend_r;
    out_res_nxt.last = 1'b0;
    if (emit_v) begin
      out_valid_nxt      = pend_v_r;
      pend_v_nxt         = 1'b1;
      pend_nxt.who       = emit_who;
      pend_nxt.event_res = emit_ev;
      pend_nxt.last      = 1'b0;
    end else if (state_r == rwl_pkg::ST_FLUSH) begin
      out_valid_nxt    = pend_v_r;
      out_res_nxt.last = 1'b1;
      pend_v_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rwl_pkg::ST_IDLE;
      rc_r      <= '0;
      wh_r      <= 1'b0;
      head_r    <= '{default: '0};
      tail_r    <= '{default: '0};
      live_r    <= '{default: '0};
      wait_r    <= '0;
      inwq_r    <= '0;
      q_r       <= 1'b0;
      t_r       <= '0;
      p_r       <= '0;
      k_r       <= '0;
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rc_r      <= rc_nxt;
      wh_r      <= wh_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      live_r    <= live_nxt;
      wait_r    <= wait_nxt;
      inwq_r    <= inwq_nxt;
      q_r       <= q_nxt;
      t_r       <= t_nxt;
      p_r       <= p_nxt;
      k_r       <= k_nxt;
      pend_v_r  <= pend_v_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    pend_r  <= pend_nxt;
    out_res <= out_res_nxt;
  end

  `RWL_ASSERT(a_no_mixed_hold, !(wh_r && rc_r != '0))
  `RWL_ASSERT(a_live_bound, (32'(live_r[0]) <= THREADS) && (32'(live_r[1]) <= THREADS))
  `RWL_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `RWL_ASSERT(a_idle_drained, (state_r != rwl_pkg::ST_IDLE) || !pend_v_r)

endmodule
`default_nettype wire

>>> rtl/core/rwl_ram.sv
// ----------------------------------------------------------------------------
// rwl_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rwl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
